@@ hdl/ffxd_pkg.sv @@
// Package for the fixed-frame XOR deframer.
// Holds frame layout constants, counter widths, register codes and shared types.
// No dependencies; every module of the block imports it.
package ffxd_pkg;

  localparam int FRAME_LEN   = 8;
  localparam int COUNT_WIDTH = 32;
  localparam int OUT_CNT_W   = 32;

  // Result payload: two flags, type byte, two 16-bit values, four counters.
  localparam int PAYLOAD_W   = 1 + 1 + 8 + 16 + 16 + 4 * OUT_CNT_W;
  localparam int TDATA_OUT_W = ((PAYLOAD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = TDATA_OUT_W - PAYLOAD_W;

  localparam logic [7:0] START_RESET = 8'hAA;
  localparam logic [7:0] END_RESET   = 8'h55;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  typedef enum logic [0:0] {
    REG_START = 1'b0,
    REG_END   = 1'b1
  } reg_idx_t;

  // What one processed byte did to the frame state.
  typedef struct packed {
    logic               done;
    logic               ok;
    logic               start_hit;
    logic [7:0]         frame_type;
    logic signed [15:0] value_first;
    logic signed [15:0] value_second;
  } frame_evt_t;

  // Counter values after the byte, already cut to the result width.
  typedef struct packed {
    logic [OUT_CNT_W-1:0] bytes_seen;
    logic [OUT_CNT_W-1:0] starts_seen;
    logic [OUT_CNT_W-1:0] bad_frames;
    logic [OUT_CNT_W-1:0] good_frames;
  } cnt_view_t;

  function automatic logic [OUT_CNT_W-1:0] to_out(cnt_t c);
    logic [63:0] w;
    w = 64'(c);
    return w[OUT_CNT_W-1:0];
  endfunction

endpackage

@@ hdl/ffxd_frame.sv @@
// Frame collector: fill position, byte store and the end-of-frame checks.
// Depends on ffxd_pkg.
module ffxd_frame (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic [7:0]         rx_byte,
  input  logic [7:0]         start_byte,
  input  logic [7:0]         end_byte,
  output ffxd_pkg::frame_evt_t evt
);
  import ffxd_pkg::*;

  logic [2:0] fill_pos;
  logic [2:0] fill_pos_next;
  logic [7:0] store [0:FRAME_LEN-2];
  logic [7:0] body_xor;
  logic       pass;

  assign body_xor = store[1] ^ store[2] ^ store[3] ^ store[4] ^ store[5];
  assign pass = (store[0] == start_byte) && (rx_byte == end_byte) && (body_xor == store[6]);

  always_comb begin
    evt           = '0;
    fill_pos_next = fill_pos;
    if (fill_pos == 3'd0) begin
      if (rx_byte == start_byte) begin
        evt.start_hit = 1'b1;
        fill_pos_next = 3'd1;
      end
    end else begin
      fill_pos_next = fill_pos + 3'd1;
      if (fill_pos == 3'(FRAME_LEN - 1)) begin
        evt.done = 1'b1;
        evt.ok   = pass;
        if (pass) begin
          evt.frame_type   = store[1];
          evt.value_first  = {store[2], store[3]};
          evt.value_second = {store[4], store[5]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_pos <= 3'd0;
    end else if (fire) begin
      fill_pos <= fill_pos_next;
    end
  end

  // The last byte of a frame is checked on the fly and never stored.
  always_ff @(posedge clk) begin
    if (fire && (fill_pos != 3'(FRAME_LEN - 1)) && ((fill_pos != 3'd0) || evt.start_hit)) begin
      store[fill_pos] <= rx_byte;
    end
  end

  a_fill_steps: assert property (@(posedge clk) disable iff (rst)
    fire && (fill_pos != 3'd0) |=> fill_pos == $past(fill_pos) + 3'd1)
    else $error("fill position did not step inside a frame");

  a_done_rehunt: assert property (@(posedge clk) disable iff (rst)
    fire && evt.done |=> fill_pos == 3'd0)
    else $error("parser did not return to hunting after a frame");

  a_ok_only_done: assert property (@(posedge clk) disable iff (rst)
    evt.ok |-> evt.done && !evt.start_hit)
    else $error("good frame flagged outside a frame end");

endmodule

@@ hdl/ffxd_counters.sv @@
// Wrapping statistics counters for bytes, starts, rejected and accepted frames.
// Depends on ffxd_pkg.
module ffxd_counters (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  ffxd_pkg::frame_evt_t evt,
  output ffxd_pkg::cnt_view_t  view
);
  import ffxd_pkg::*;

  cnt_t byte_cnt, start_cnt, reject_cnt, accept_cnt;
  cnt_t byte_cnt_next, start_cnt_next, reject_cnt_next, accept_cnt_next;

  always_comb begin
    byte_cnt_next   = byte_cnt + cnt_t'(1);
    start_cnt_next  = evt.start_hit ? start_cnt + cnt_t'(1) : start_cnt;
    reject_cnt_next = (evt.done && !evt.ok) ? reject_cnt + cnt_t'(1) : reject_cnt;
    accept_cnt_next = (evt.done && evt.ok) ? accept_cnt + cnt_t'(1) : accept_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_cnt   <= '0;
      start_cnt  <= '0;
      reject_cnt <= '0;
      accept_cnt <= '0;
    end else if (fire) begin
      byte_cnt   <= byte_cnt_next;
      start_cnt  <= start_cnt_next;
      reject_cnt <= reject_cnt_next;
      accept_cnt <= accept_cnt_next;
    end
  end

  // Results report the counts including the byte being processed.
  assign view.bytes_seen  = to_out(byte_cnt_next);
  assign view.starts_seen = to_out(start_cnt_next);
  assign view.bad_frames  = to_out(reject_cnt_next);
  assign view.good_frames = to_out(accept_cnt_next);

endmodule

@@ hdl/fixed_frame_xor_deframer.sv @@
// Top level of the fixed-frame XOR deframer: streams, APB registers, pipeline.
// Depends on ffxd_pkg, ffxd_frame and ffxd_counters.
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata[7:0] = rx_byte
// m_*       out  m_tvalid/m_tready  m_tdata[175:0] = one result per byte
// APB       in   psel/penable       start_byte at 0x0, end_byte at 0x4
//
// Each byte passes through the input register, then is processed and loads the
// result register. A byte can be accepted every cycle unless the output stalls.
// Reset (rst, synchronous) clears the parser to hunting, the counters and
// the registers to their defaults. A stalled result register stalls the
// input register, which still accepts a transfer whenever it drains in the
// same cycle.
module fixed_frame_xor_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte[7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  // frame_ok[0], frame_bad[1], frame_type[9:2], value_first[25:10],
  // value_second[41:26], bytes_seen[73:42], starts_seen[105:74],
  // bad_frames[137:106], good_frames[169:138], zero pad[175:170]
  output logic [ffxd_pkg::TDATA_OUT_W-1:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ffxd_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;
  logic       fire;
  logic [7:0] start_byte;
  logic [7:0] end_byte;
  reg_idx_t   reg_idx;
  frame_evt_t evt;
  cnt_view_t  view;
  logic [TDATA_OUT_W-1:0] result;

  // Configuration registers. Only bit 2 of the address selects a register.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_RESET;
      end_byte   <= END_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_START: start_byte <= pwdata[7:0];
        REG_END:   end_byte   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_START: prdata = {24'd0, start_byte};
      REG_END:   prdata = {24'd0, end_byte};
      default:   prdata = '0;
    endcase
  end

  // The input register moves into the result register whenever the result
  // register is empty or being emptied by the downstream transfer.
  assign advance  = !m_tvalid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  ffxd_frame u_frame (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .rx_byte    (in_byte),
    .start_byte (start_byte),
    .end_byte   (end_byte),
    .evt        (evt)
  );

  ffxd_counters u_counters (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .evt  (evt),
    .view (view)
  );

  // Result register and its valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= {{OUT_PAD_W{1'b0}}, view.good_frames, view.bad_frames, view.starts_seen,
                 view.bytes_seen, evt.value_second, evt.value_first, evt.frame_type,
                 evt.done && !evt.ok, evt.ok};
    end
  end

  assign m_tdata = result;

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("result flagged both good and bad");

  a_fire_fills: assert property (@(posedge clk) disable iff (rst)
    fire |=> m_tvalid)
    else $error("processed byte produced no result");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && m_tvalid && !m_tready)
    else $error("input stalled without a downstream stall");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    fire && m_tvalid && m_tready |=> m_tdata[73:42] == $past(m_tdata[73:42]) + 32'd1)
    else $error("byte count did not advance by one");

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for fixed_frame_xor_deframer: bytes go in on the
// slave stream, every result is checked against an in-bench frame parser.
// Depends on ffxd_pkg and the RTL of the block; it reads no files.
module testbench;
  import ffxd_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_LIMIT = 10;

  // One result as the block reports it after a byte.
  typedef struct packed {
    logic               ok;
    logic               bad;
    logic [7:0]         ftype;
    logic signed [15:0] v_first;
    logic signed [15:0] v_second;
    logic [31:0]        bytes_seen;
    logic [31:0]        starts_seen;
    logic [31:0]        bad_frames;
    logic [31:0]        good_frames;
  } frame_result_t;

  // Ways a generated frame can be spoiled.
  typedef enum {FLAW_NONE, FLAW_CHECKSUM, FLAW_END, FLAW_TRUNCATED} frame_flaw_t;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_tdata;
  logic                   psel     = 1'b0;
  logic                   penable  = 1'b0;
  logic                   pwrite   = 1'b0;
  logic [2:0]             paddr    = '0;
  logic [31:0]            pwdata   = '0;
  logic [31:0]            prdata;
  logic                   pready;

  fixed_frame_xor_deframer uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // Parser state mirrored in the bench, including the register settings.
  logic [7:0]      cfg_start  = START_RESET;
  logic [7:0]      cfg_end    = END_RESET;
  logic [2:0]      fill_pos   = '0;
  logic [7:0]      frame_buf [FRAME_LEN];
  cnt_t            byte_cnt   = '0;
  cnt_t            start_cnt  = '0;
  cnt_t            reject_cnt = '0;
  cnt_t            accept_cnt = '0;
  frame_result_t   pending_results [$];

  int unsigned failures     = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count  = 0;
  int unsigned hold_request = 0;
  int unsigned stall_left   = 0;
  bit          tx_idle      = 1'b1;
  bit          rx_idle      = 1'b1;

  // Advances the mirrored parser by one byte and returns the result it owes.
  function automatic frame_result_t parse_byte(logic [7:0] b);
    frame_result_t r;
    logic [7:0]    body_xor;
    r = '0;
    byte_cnt++;
    if (fill_pos == 0) begin
      // Hunting: only the start byte opens a frame.
      if (b == cfg_start) begin
        frame_buf[0] = b;
        fill_pos = 3'd1;
        start_cnt++;
      end
    end else begin
      frame_buf[fill_pos] = b;
      fill_pos = fill_pos + 3'd1;  // wraps to zero on the end byte
      if (fill_pos == 0) begin
        body_xor = frame_buf[1] ^ frame_buf[2] ^ frame_buf[3] ^ frame_buf[4] ^ frame_buf[5];
        // The start check uses the register as it is now, not as it was
        // when the frame opened.
        if (frame_buf[0] == cfg_start && frame_buf[7] == cfg_end &&
            body_xor == frame_buf[6]) begin
          r.ok       = 1'b1;
          r.ftype    = frame_buf[1];
          r.v_first  = {frame_buf[2], frame_buf[3]};
          r.v_second = {frame_buf[4], frame_buf[5]};
          accept_cnt++;
        end else begin
          r.bad = 1'b1;
          reject_cnt++;
        end
      end
    end
    r.bytes_seen  = byte_cnt[31:0];
    r.starts_seen = start_cnt[31:0];
    r.bad_frames  = reject_cnt[31:0];
    r.good_frames = accept_cnt[31:0];
    return r;
  endfunction

  task automatic flag_failure(string msg);
    failures++;
    if (failures <= REPORT_LIMIT) $display("%s", msg);
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want)
      flag_failure($sformatf("result %0d: %s expected %h, got %h",
                             results_seen, name, want, got));
  endtask

  // Unpacks one result transfer and compares it with the oldest expectation.
  task automatic check_result(logic [TDATA_OUT_W-1:0] d);
    frame_result_t want;
    frame_result_t got;
    got.ok          = d[0];
    got.bad         = d[1];
    got.ftype       = d[9:2];
    got.v_first     = d[25:10];
    got.v_second    = d[41:26];
    got.bytes_seen  = d[73:42];
    got.starts_seen = d[105:74];
    got.bad_frames  = d[137:106];
    got.good_frames = d[169:138];
    results_seen++;
    if (pending_results.size() == 0) begin
      flag_failure($sformatf("result %0d arrived with nothing expected", results_seen));
    end else begin
      want = pending_results.pop_front();
      compare_field("frame_ok", 32'(want.ok), 32'(got.ok));
      compare_field("frame_bad", 32'(want.bad), 32'(got.bad));
      compare_field("frame_type", 32'(want.ftype), 32'(got.ftype));
      compare_field("value_first", 32'(want.v_first), 32'(got.v_first));
      compare_field("value_second", 32'(want.v_second), 32'(got.v_second));
      compare_field("bytes_seen", want.bytes_seen, got.bytes_seen);
      compare_field("starts_seen", want.starts_seen, got.starts_seen);
      compare_field("bad_frames", want.bad_frames, got.bad_frames);
      compare_field("good_frames", want.good_frames, got.good_frames);
    end
  endtask

  // Result side: checks every transfer, then, while rx_idle is set, stalls
  // at random before the next one. A hold request from the test overrides the
  // stall and is counted down here, cycle by cycle.
  always @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      check_result(m_tdata);
      stall_left = rx_idle ? $urandom_range(0, 7) : 0;
    end
    if (hold_request != 0) begin
      stall_left = hold_request;
      hold_request = 0;
    end
    if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("fixed_frame_xor_deframer regression: fail");
      $finish;
    end
  end

  // Offers one byte, after a random gap if tx_idle is set, and waits for its
  // transfer. tvalid stays high afterwards so that back-to-back bytes need no new edge.
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(parse_byte(b));
  endtask

  // Stops offering bytes and waits until every expected result has arrived.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic apb_access(reg_idx_t idx, logic write, logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= 3'(idx) << 2;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_readback(reg_idx_t idx, logic [7:0] want);
    logic [31:0] rdata;
    apb_access(idx, 1'b0, '0, rdata);
    if (rdata[7:0] !== want)
      flag_failure($sformatf("register %s reads %h, expected %h", idx.name(), rdata[7:0], want));
  endtask

  // Writes a register once the stream is idle; the upper bits of the write
  // data are random and must be dropped by the block.
  task automatic set_register(reg_idx_t idx, logic [7:0] value);
    logic [31:0] wdata;
    logic [31:0] unused;
    wait_drained();
    wdata = $urandom();
    wdata[7:0] = value;
    apb_access(idx, 1'b1, wdata, unused);
    if (idx == REG_START) cfg_start = value;
    else cfg_end = value;
    check_readback(idx, value);
  endtask

  task automatic send_frame(logic [7:0] ftype, logic [15:0] v_first, logic [15:0] v_second,
                            frame_flaw_t flaw);
    logic [7:0] f [FRAME_LEN];
    int         len;
    int         i;
    f[0] = cfg_start;
    f[1] = ftype;
    f[2] = v_first[15:8];
    f[3] = v_first[7:0];
    f[4] = v_second[15:8];
    f[5] = v_second[7:0];
    f[6] = f[1] ^ f[2] ^ f[3] ^ f[4] ^ f[5];
    f[7] = cfg_end;
    if (flaw == FLAW_CHECKSUM) f[6] ^= 8'(1 << $urandom_range(0, 7));
    if (flaw == FLAW_END) f[7] = cfg_end ^ 8'($urandom_range(1, 255));
    len = (flaw == FLAW_TRUNCATED) ? $urandom_range(1, 7) : FRAME_LEN;
    for (i = 0; i < len; i++) send_byte(f[i]);
  endtask

  // Feeds random bytes until the parser is hunting again, so that the next
  // frame lines up with the frame boundary.
  task automatic finish_partial_frame();
    while (fill_pos != 0) send_byte(8'($urandom()));
  endtask

  task automatic test_directed();
    check_readback(REG_START, START_RESET);
    check_readback(REG_END, END_RESET);
    // Noise at both extremes while hunting.
    send_byte(8'h00);
    send_byte(8'hFF);
    // Good frame with the extreme signed values.
    send_frame(8'hFF, 16'h8000, 16'h7FFF, FLAW_NONE);
    // A bad checksum with the start byte inside the body: after the reject
    // the parser must not rescan the buffered bytes.
    send_frame(8'h01, {cfg_start, 8'h00}, {8'h00, cfg_start}, FLAW_CHECKSUM);
    // The start byte register changes in the middle of a frame, so the
    // otherwise valid frame fails the start check.
    send_byte(cfg_start);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    set_register(REG_START, 8'h3C);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(cfg_end);
    wait_drained();
  endtask

  // The receiver holds off for a long stretch while the sender keeps going,
  // so the block fills and stalls its input; the sender waits until everything
  // has drained, then sends two more frames with random gaps.
  task automatic test_backpressure();
    int i;
    set_register(REG_START, START_RESET);
    finish_partial_frame();
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    hold_request = 300;
    for (i = 0; i < 5; i++)
      send_frame(8'($urandom()), 16'($urandom()), 16'($urandom()), FLAW_NONE);
    wait_drained();
    tx_idle = 1'b1;
    for (i = 0; i < 2; i++)
      send_frame(8'($urandom()), 16'($urandom()), 16'($urandom()), FLAW_NONE);
    wait_drained();
  endtask

  // Mostly well-formed frames with random content, with some spoiled frames
  // and stray bytes mixed in.
  task automatic run_random_frames(int count);
    int i;
    int pick;
    frame_flaw_t flaw;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 85) finish_partial_frame();
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) send_byte(8'($urandom()));
      pick = $urandom_range(0, 99);
      if (pick < 70) flaw = FLAW_NONE;
      else if (pick < 80) flaw = FLAW_CHECKSUM;
      else if (pick < 90) flaw = FLAW_END;
      else flaw = FLAW_TRUNCATED;
      send_frame(8'($urandom()), 16'($urandom()), 16'($urandom()), flaw);
    end
  endtask

  // Several register settings, extremes among them, each with one of the four
  // mixes of idling on the two sides.
  task automatic test_config_sweep();
    logic [7:0] start_set [6];
    logic [7:0] end_set [6];
    int         phase;
    start_set = '{8'h00, 8'hFF, START_RESET, 8'h5A, 8'h00, 8'h00};
    end_set   = '{8'hFF, 8'h00, END_RESET, 8'h5A, 8'h00, 8'h00};
    start_set[4] = 8'($urandom());
    end_set[4]   = 8'($urandom());
    start_set[5] = 8'($urandom());
    end_set[5]   = 8'($urandom());
    for (phase = 0; phase < 6; phase++) begin
      set_register(REG_START, start_set[phase]);
      set_register(REG_END, end_set[phase]);
      tx_idle = (phase % 4 == 0) || (phase % 4 == 1);
      rx_idle = (phase % 4 == 0) || (phase % 4 == 2);
      run_random_frames(18);
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_config_sweep();
    // Returns only once every expectation has been met; a missing result
    // ends the run at the cycle limit instead.
    wait_drained();
    repeat (10) @(posedge clk);
    if (failures == 0) $display("fixed_frame_xor_deframer regression: pass");
    else $display("fixed_frame_xor_deframer regression: fail");
    $finish;
  end

endmodule
